[rtl/core/gcns_pkg.sv]
// Shared constants, item codes and item types of the grid cell neighbor search block.
package gcns_pkg;

  // Coordinates are Q1.15 signed; the radius uses the same units.
  localparam int COORD_BITS = 16;
  localparam int GRID_DIVISIONS_DEF = 16;
  localparam int ENTITY_SLOTS_DEF = 256;
  localparam int MAX_RESULTS = 64;
  localparam logic [6:0] MAX_MATCHES_RESET = 7'd16;

  // Item kinds.
  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_MOVE   = 3'd2;
  localparam logic [2:0] KIND_QPOINT = 3'd3;
  localparam logic [2:0] KIND_QENT   = 3'd4;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         entity_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        search_radius;
  } in_item_t;

  typedef struct packed {
    logic [7:0] found_entity;
    logic       found;
    logic       last;
    logic [6:0] match_count;
  } out_item_t;

endpackage

[rtl/core/grid_cell_neighbor_search.sv]
// Uniform 3-D grid with per-cell linked lists of entities, and radius queries over it.
// A query does one RAM read per list step and uses one shared multiplier for the squared
// distance. One item is in work at a time; each result is shown for one cycle.
// After reset the cell head table is cleared, one cell a cycle.
module grid_cell_neighbor_search import gcns_pkg::*; #(
  parameter int GRID_DIVISIONS = GRID_DIVISIONS_DEF,
  parameter int ENTITY_SLOTS   = ENTITY_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [6:0] cfg_wdata
);

  localparam int CB    = COORD_BITS;
  localparam int DW    = CB + 1;
  localparam int SW    = 2 * DW + 2;
  localparam int CELLS = GRID_DIVISIONS * GRID_DIVISIONS * GRID_DIVISIONS;
  localparam int AW    = $clog2(GRID_DIVISIONS);
  localparam int CW    = $clog2(CELLS);
  localparam int SLW   = $clog2(ENTITY_SLOTS);
  localparam int LW    = $clog2(ENTITY_SLOTS + 1);
  localparam int STW   = $clog2(ENTITY_SLOTS + 1);
  localparam int TW    = CB + 10;
  localparam logic [LW-1:0] NULL_LINK = LW'(ENTITY_SLOTS);
  localparam logic signed [TW-1:0] T_HALF = TW'(1 << (CB - 1));
  localparam logic signed [TW-1:0] T_DIV  = TW'(GRID_DIVISIONS);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_CLR   = 5'd1;
  localparam logic [4:0] ST_PRD   = 5'd2;
  localparam logic [4:0] ST_PRW   = 5'd3;
  localparam logic [4:0] ST_AXIS  = 5'd4;
  localparam logic [4:0] ST_SQR   = 5'd5;
  localparam logic [4:0] ST_UA    = 5'd6;
  localparam logic [4:0] ST_UB    = 5'd7;
  localparam logic [4:0] ST_UC    = 5'd8;
  localparam logic [4:0] ST_UD    = 5'd9;
  localparam logic [4:0] ST_LA    = 5'd10;
  localparam logic [4:0] ST_LB    = 5'd11;
  localparam logic [4:0] ST_LC    = 5'd12;
  localparam logic [4:0] ST_MVRD  = 5'd13;
  localparam logic [4:0] ST_MVCMP = 5'd14;
  localparam logic [4:0] ST_FIN   = 5'd15;
  localparam logic [4:0] ST_QH    = 5'd16;
  localparam logic [4:0] ST_QHW   = 5'd17;
  localparam logic [4:0] ST_QE    = 5'd18;
  localparam logic [4:0] ST_QEW   = 5'd19;
  localparam logic [4:0] ST_QD    = 5'd20;
  localparam logic [4:0] ST_QC    = 5'd21;

  // Maps one coordinate, possibly offset by the radius, to its cell on one axis.
  function automatic logic [AW-1:0] axis_cell(input logic signed [CB+1:0] v);
    logic signed [TW-1:0] t;
    logic [9:0]           c;
    t = ($signed({{8{v[CB+1]}}, v}) + T_HALF) * T_DIV + T_HALF;
    c = t[CB+9:CB];
    if (t < 0) begin
      return '0;
    end
    if (c > 10'(GRID_DIVISIONS - 1)) begin
      return AW'(GRID_DIVISIONS - 1);
    end
    return AW'(c);
  endfunction

  // Linear cell index with x outermost and z innermost.
  function automatic logic [CW-1:0] cell_index(input logic [AW-1:0] x, input logic [AW-1:0] y,
                                               input logic [AW-1:0] z);
    return (CW'(x) * CW'(GRID_DIVISIONS) + CW'(y)) * CW'(GRID_DIVISIONS) + CW'(z);
  endfunction

  // Control registers.
  logic [4:0]              state_r, state_nxt;
  logic [CW-1:0]           clr_r, clr_nxt;
  logic [ENTITY_SLOTS-1:0] member_r, member_nxt;
  logic                    out_v_r, out_v_nxt;
  logic [6:0]              max_r;
  logic                    pend_v_r, pend_v_nxt;

  // Payload registers.
  logic [2:0]           kind_r, kind_nxt;
  logic [SLW-1:0]       id_r, id_nxt;
  logic signed [CB-1:0] pos_r [3];
  logic signed [CB-1:0] pos_nxt [3];
  logic [CB-1:0]        rad_r, rad_nxt;
  logic [6:0]           lim_r, lim_nxt;
  logic [AW-1:0]        lo_r [3];
  logic [AW-1:0]        lo_nxt [3];
  logic [AW-1:0]        hi_r [3];
  logic [AW-1:0]        hi_nxt [3];
  logic [AW-1:0]        x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [2:0]           ax_r, ax_nxt;
  logic [CW-1:0]        uc_r, uc_nxt;
  logic [LW-1:0]        un_r, un_nxt, up_r, up_nxt, h_r, h_nxt;
  logic [LW-1:0]        e_r, e_nxt, nx_r, nx_nxt;
  logic signed [CB-1:0] q_r [3];
  logic signed [CB-1:0] q_nxt [3];
  logic [STW-1:0]       steps_r, steps_nxt;
  logic [1:0]           dax_r, dax_nxt;
  logic [SW-1:0]        acc_r, acc_nxt;
  logic [2*CB-1:0]      r2_r, r2_nxt;
  logic [6:0]           cnt_r, cnt_nxt;
  logic [7:0]           pend_e_r, pend_e_nxt;
  logic [6:0]           pend_c_r, pend_c_nxt;
  out_item_t            out_r, out_nxt;

  // RAM ports.
  logic             hd_we, nl_we, pl_we, ps_we, ec_we;
  logic [CW-1:0]    hd_wa, hd_ra;
  logic [LW-1:0]    hd_wd, hd_rd;
  logic [SLW-1:0]   nl_wa, nl_ra, pl_wa, pl_ra, ps_wa, ps_ra, ec_wa, ec_ra;
  logic [LW-1:0]    nl_wd, nl_rd, pl_wd, pl_rd;
  logic [3*CB-1:0]  ps_wd, ps_rd;
  logic [CW-1:0]    ec_wd, ec_rd;

  // Shared datapath pieces.
  logic                 in_valid_id;
  logic [6:0]           lim_in;
  logic [1:0]           ax_sel;
  logic signed [CB+1:0] ax_val;
  logic [AW-1:0]        ax_cell;
  logic [CW-1:0]        cell_new;
  logic [CW-1:0]        cell_cur;
  logic signed [DW-1:0] dsub;
  logic [DW-1:0]        dabs;
  logic [DW-1:0]        mul_a;
  logic [2*DW-1:0]      prod;
  logic                 e_valid;
  logic [6:0]           cnt_inc;
  logic                 excl;

  gcns_ram #(.WIDTH(LW), .DEPTH(CELLS)) u_head (
    .clk(clk), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
  gcns_ram #(.WIDTH(LW), .DEPTH(ENTITY_SLOTS)) u_next (
    .clk(clk), .we(nl_we), .waddr(nl_wa), .wdata(nl_wd), .raddr(nl_ra), .rdata(nl_rd));
  gcns_ram #(.WIDTH(LW), .DEPTH(ENTITY_SLOTS)) u_prev (
    .clk(clk), .we(pl_we), .waddr(pl_wa), .wdata(pl_wd), .raddr(pl_ra), .rdata(pl_rd));
  gcns_ram #(.WIDTH(3 * CB), .DEPTH(ENTITY_SLOTS)) u_pos (
    .clk(clk), .we(ps_we), .waddr(ps_wa), .wdata(ps_wd), .raddr(ps_ra), .rdata(ps_rd));
  gcns_ram #(.WIDTH(CW), .DEPTH(ENTITY_SLOTS)) u_cell (
    .clk(clk), .we(ec_we), .waddr(ec_wa), .wdata(ec_wd), .raddr(ec_ra), .rdata(ec_rd));

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_v_r;
  assign out_item   = out_r;

  // Item decode helpers.
  assign in_valid_id = (32'(in_item.entity_id) < ENTITY_SLOTS);
  assign lim_in = (max_r == 7'd0) ? 7'd1 :
                  (max_r > 7'(MAX_RESULTS)) ? 7'(MAX_RESULTS) : max_r;
  assign excl = (kind_r == KIND_QENT);

  // Shared axis mapping unit: even steps give the low cell, odd steps the high cell.
  assign ax_sel  = ax_r[2:1];
  assign ax_val  = ax_r[0] ? ({{2{pos_r[ax_sel][CB-1]}}, pos_r[ax_sel]} + {2'b00, rad_r})
                           : ({{2{pos_r[ax_sel][CB-1]}}, pos_r[ax_sel]} - {2'b00, rad_r});
  assign ax_cell = axis_cell(ax_val);
  assign cell_new = cell_index(lo_r[0], lo_r[1], lo_r[2]);
  assign cell_cur = cell_index(x_r, y_r, z_r);

  // Shared multiplier: squares the radius, then each axis distance.
  assign dsub  = {pos_r[dax_r][CB-1], pos_r[dax_r]} - {q_r[dax_r][CB-1], q_r[dax_r]};
  assign dabs  = dsub[DW-1] ? DW'(-dsub) : DW'(dsub);
  assign mul_a = (state_r == ST_SQR) ? DW'(rad_r) : dabs;
  assign prod  = mul_a * mul_a;

  assign e_valid = (e_r < NULL_LINK);
  assign cnt_inc = cnt_r + 7'd1;

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    member_nxt = member_r;
    out_v_nxt  = 1'b0;
    out_nxt    = out_r;
    pend_v_nxt = pend_v_r;
    pend_e_nxt = pend_e_r;
    pend_c_nxt = pend_c_r;
    kind_nxt   = kind_r;
    id_nxt     = id_r;
    pos_nxt    = pos_r;
    rad_nxt    = rad_r;
    lim_nxt    = lim_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    z_nxt      = z_r;
    ax_nxt     = ax_r;
    uc_nxt     = uc_r;
    un_nxt     = un_r;
    up_nxt     = up_r;
    h_nxt      = h_r;
    e_nxt      = e_r;
    nx_nxt     = nx_r;
    q_nxt      = q_r;
    steps_nxt  = steps_r;
    dax_nxt    = dax_r;
    acc_nxt    = acc_r;
    r2_nxt     = r2_r;
    cnt_nxt    = cnt_r;

    hd_we = 1'b0; hd_wa = uc_r;    hd_wd = nl_rd; hd_ra = cell_cur;
    nl_we = 1'b0; nl_wa = id_r;    nl_wd = NULL_LINK; nl_ra = id_r;
    pl_we = 1'b0; pl_wa = id_r;    pl_wd = NULL_LINK; pl_ra = id_r;
    ps_we = 1'b0; ps_wa = id_r;    ps_wd = {pos_r[0], pos_r[1], pos_r[2]}; ps_ra = id_r;
    ec_we = 1'b0; ec_wa = id_r;    ec_wd = cell_new;  ec_ra = id_r;

    case (state_r)
      ST_CLR: begin
        hd_we = 1'b1;
        hd_wa = clr_r;
        hd_wd = NULL_LINK;
        clr_nxt = clr_r + CW'(1);
        if (clr_r == CW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          kind_nxt   = in_item.kind;
          id_nxt     = SLW'(in_item.entity_id);
          pos_nxt[0] = in_item.pos_x;
          pos_nxt[1] = in_item.pos_y;
          pos_nxt[2] = in_item.pos_z;
          rad_nxt    = '0;
          lim_nxt    = lim_in;
          ax_nxt     = '0;
          cnt_nxt    = '0;
          pend_v_nxt = 1'b0;
          case (in_item.kind)
            KIND_INSERT, KIND_MOVE: begin
              state_nxt = in_valid_id ? ST_AXIS : ST_FIN;
            end
            KIND_REMOVE: begin
              state_nxt = (in_valid_id && member_r[SLW'(in_item.entity_id)]) ? ST_UA : ST_FIN;
            end
            KIND_QPOINT: begin
              rad_nxt   = in_item.search_radius;
              state_nxt = ST_AXIS;
            end
            KIND_QENT: begin
              rad_nxt   = in_item.search_radius;
              state_nxt = in_valid_id ? ST_PRD : ST_FIN;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end

      // Entity query: fetch the stored position as the query point.
      ST_PRD: begin
        ps_ra = id_r;
        state_nxt = ST_PRW;
      end

      ST_PRW: begin
        pos_nxt[0] = ps_rd[3*CB-1:2*CB];
        pos_nxt[1] = ps_rd[2*CB-1:CB];
        pos_nxt[2] = ps_rd[CB-1:0];
        state_nxt  = ST_AXIS;
      end

      // Six passes through the axis unit give the cell ranges.
      ST_AXIS: begin
        if (ax_r[0]) begin
          hi_nxt[ax_sel] = ax_cell;
        end else begin
          lo_nxt[ax_sel] = ax_cell;
        end
        if ((ax_r == 3'd0) && (kind_r inside {KIND_INSERT, KIND_MOVE})) begin
          ps_we = 1'b1;
        end
        ax_nxt = ax_r + 3'd1;
        if (ax_r == 3'd5) begin
          case (kind_r)
            KIND_INSERT: state_nxt = member_r[id_r] ? ST_UA : ST_LA;
            KIND_MOVE:   state_nxt = member_r[id_r] ? ST_MVRD : ST_FIN;
            default:     state_nxt = ST_SQR;
          endcase
        end
      end

      ST_MVRD: begin
        ec_ra = id_r;
        state_nxt = ST_MVCMP;
      end

      ST_MVCMP: begin
        state_nxt = (ec_rd != cell_new) ? ST_UA : ST_FIN;
      end

      // Unlink: read the entity's cell and neighbors, then patch the list.
      ST_UA: begin
        ec_ra = id_r;
        nl_ra = id_r;
        pl_ra = id_r;
        state_nxt = ST_UB;
      end

      ST_UB: begin
        uc_nxt = ec_rd;
        un_nxt = nl_rd;
        up_nxt = pl_rd;
        hd_ra  = ec_rd;
        state_nxt = ST_UC;
      end

      ST_UC: begin
        if (hd_rd == LW'(id_r)) begin
          hd_we = 1'b1;
          hd_wa = uc_r;
          hd_wd = un_r;
        end
        if (un_r < NULL_LINK) begin
          pl_we = 1'b1;
          pl_wa = un_r[SLW-1:0];
          pl_wd = up_r;
        end
        if (up_r < NULL_LINK) begin
          nl_we = 1'b1;
          nl_wa = up_r[SLW-1:0];
          nl_wd = un_r;
        end
        state_nxt = ST_UD;
      end

      ST_UD: begin
        nl_we = 1'b1;
        pl_we = 1'b1;
        member_nxt[id_r] = 1'b0;
        state_nxt = (kind_r == KIND_REMOVE) ? ST_FIN : ST_LA;
      end

      // Link at the head of the new cell.
      ST_LA: begin
        hd_ra = cell_new;
        state_nxt = ST_LB;
      end

      ST_LB: begin
        h_nxt = hd_rd;
        ec_we = 1'b1;
        nl_we = 1'b1;
        nl_wd = hd_rd;
        pl_we = 1'b1;
        hd_we = 1'b1;
        hd_wa = cell_new;
        hd_wd = LW'(id_r);
        member_nxt[id_r] = 1'b1;
        state_nxt = ST_LC;
      end

      ST_LC: begin
        if (h_r < NULL_LINK) begin
          pl_we = 1'b1;
          pl_wa = h_r[SLW-1:0];
          pl_wd = LW'(id_r);
        end
        state_nxt = ST_FIN;
      end

      // Squared radius, then start at the lowest cell.
      ST_SQR: begin
        r2_nxt = (2*CB)'(prod);
        x_nxt  = lo_r[0];
        y_nxt  = lo_r[1];
        z_nxt  = lo_r[2];
        state_nxt = ST_QH;
      end

      ST_QH: begin
        hd_ra = cell_cur;
        state_nxt = ST_QHW;
      end

      ST_QHW: begin
        e_nxt     = hd_rd;
        steps_nxt = '0;
        state_nxt = ST_QE;
      end

      // Step along the list, or move on to the next cell.
      ST_QE: begin
        if (e_valid && (steps_r < STW'(ENTITY_SLOTS))) begin
          ps_ra = e_r[SLW-1:0];
          nl_ra = e_r[SLW-1:0];
          steps_nxt = steps_r + STW'(1);
          state_nxt = ST_QEW;
        end else if (z_r != hi_r[2]) begin
          z_nxt = z_r + AW'(1);
          state_nxt = ST_QH;
        end else if (y_r != hi_r[1]) begin
          y_nxt = y_r + AW'(1);
          z_nxt = lo_r[2];
          state_nxt = ST_QH;
        end else if (x_r != hi_r[0]) begin
          x_nxt = x_r + AW'(1);
          y_nxt = lo_r[1];
          z_nxt = lo_r[2];
          state_nxt = ST_QH;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_QEW: begin
        q_nxt[0] = ps_rd[3*CB-1:2*CB];
        q_nxt[1] = ps_rd[2*CB-1:CB];
        q_nxt[2] = ps_rd[CB-1:0];
        nx_nxt   = nl_rd;
        dax_nxt  = '0;
        acc_nxt  = '0;
        if (excl && (e_r == LW'(id_r))) begin
          e_nxt = nl_rd;
          state_nxt = ST_QE;
        end else begin
          state_nxt = ST_QD;
        end
      end

      // One axis of the squared distance per cycle.
      ST_QD: begin
        acc_nxt = acc_r + SW'(prod);
        dax_nxt = dax_r + 2'd1;
        if (dax_r == 2'd2) begin
          state_nxt = ST_QC;
        end
      end

      // Compare; a match pushes out the previously held one.
      ST_QC: begin
        e_nxt = nx_r;
        state_nxt = ST_QE;
        if (acc_r < SW'(r2_r)) begin
          if (pend_v_r) begin
            out_v_nxt = 1'b1;
            out_nxt   = '{found_entity: pend_e_r, found: 1'b1, last: 1'b0,
                          match_count: pend_c_r};
          end
          pend_v_nxt = 1'b1;
          pend_e_nxt = 8'(e_r);
          pend_c_nxt = cnt_inc;
          cnt_nxt    = cnt_inc;
          if (cnt_inc >= lim_r) begin
            state_nxt = ST_FIN;
          end
        end
      end

      // Final result: the held match, or an acknowledgement.
      ST_FIN: begin
        out_v_nxt = 1'b1;
        if (pend_v_r) begin
          out_nxt = '{found_entity: pend_e_r, found: 1'b1, last: 1'b1, match_count: pend_c_r};
        end else begin
          out_nxt = '{found_entity: 8'd0, found: 1'b0, last: 1'b1, match_count: 7'd0};
        end
        pend_v_nxt = 1'b0;
        state_nxt  = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      clr_r    <= '0;
      member_r <= '0;
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      max_r    <= MAX_MATCHES_RESET;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      member_r <= member_nxt;
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_r    <= out_nxt;
    pend_e_r <= pend_e_nxt;
    pend_c_r <= pend_c_nxt;
    kind_r   <= kind_nxt;
    id_r     <= id_nxt;
    pos_r    <= pos_nxt;
    rad_r    <= rad_nxt;
    lim_r    <= lim_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    ax_r     <= ax_nxt;
    uc_r     <= uc_nxt;
    un_r     <= un_nxt;
    up_r     <= up_nxt;
    h_r      <= h_nxt;
    e_r      <= e_nxt;
    nx_r     <= nx_nxt;
    q_r      <= q_nxt;
    steps_r  <= steps_nxt;
    dax_r    <= dax_nxt;
    acc_r    <= acc_nxt;
    r2_r     <= r2_nxt;
    cnt_r    <= cnt_nxt;
  end

endmodule

[rtl/core/gcns_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module gcns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sim/grid_cell_neighbor_search_checker.sv]
// Checker for the grid cell neighbor search block: tracks the grid and compares every result.
`timescale 1ns / 1ps

module grid_cell_neighbor_search_checker import gcns_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_strobe,
  input  out_item_t out_item,
  input  logic      cfg_we,
  input  logic [6:0] cfg_wdata,
  output int        error_count,
  output int        pending_count,
  output int        item_count,
  output int        match_total
);

  localparam int GRID = GRID_DIVISIONS_DEF;
  localparam int SLOTS = ENTITY_SLOTS_DEF;
  localparam int CELLS = GRID * GRID * GRID;
  localparam logic [8:0] NO_SLOT = 9'(SLOTS);

  // Shadow copy of the block's state.
  logic [6:0]   match_limit_reg;
  logic [8:0]   head_of[CELLS];
  logic [8:0]   next_of[SLOTS];
  logic [8:0]   prev_of[SLOTS];
  longint       where_x[SLOTS];
  longint       where_y[SLOTS];
  longint       where_z[SLOTS];
  int unsigned  home_cell[SLOTS];
  bit           linked[SLOTS];

  out_item_t    expected_results[$];

  // Map one coordinate to its cell on one axis, with rounding and clamping.
  function automatic int unsigned axis_cell(longint v);
    longint t;
    t = (v + 32768) * GRID + 32768;
    if (t < 0) return 0;
    if ((t >>> 16) > GRID - 1) return GRID - 1;
    return int'(t >>> 16);
  endfunction

  function automatic int unsigned cell_at(longint x, longint y, longint z);
    return (axis_cell(x) * GRID + axis_cell(y)) * GRID + axis_cell(z);
  endfunction

  function automatic void unlink_slot(int e);
    int c;
    logic [8:0] n;
    logic [8:0] p;
    c = home_cell[e] % CELLS;
    n = next_of[e];
    p = prev_of[e];
    if (head_of[c] == 9'(e)) head_of[c] = n;
    if (n < NO_SLOT) prev_of[n] = p;
    if (p < NO_SLOT) next_of[p] = n;
    next_of[e] = NO_SLOT;
    prev_of[e] = NO_SLOT;
    linked[e] = 0;
  endfunction

  function automatic void link_slot(int e);
    int c;
    logic [8:0] h;
    c = cell_at(where_x[e], where_y[e], where_z[e]);
    h = head_of[c];
    home_cell[e] = c;
    prev_of[e] = NO_SLOT;
    next_of[e] = h;
    if (h < NO_SLOT) prev_of[h] = 9'(e);
    head_of[c] = 9'(e);
    linked[e] = 1;
  endfunction

  function automatic void push_ack();
    out_item_t r;
    r = '0;
    r.last = 1'b1;
    expected_results.push_back(r);
  endfunction

  function automatic longint unsigned sq(longint a, longint b);
    longint d;
    d = (a >= b) ? a - b : b - a;
    return longint'(d) * longint'(d);
  endfunction

  // Walk the cells around the query point and queue one result per match.
  function automatic void run_query(in_item_t it);
    longint px, py, pz, r;
    longint unsigned r2, d2;
    int limit, cnt, steps, id;
    int lx, hx, ly, hy, lz, hz;
    logic [8:0] e;
    bit skip_self;
    out_item_t m;
    id = it.entity_id;
    skip_self = (it.kind == KIND_QENT);
    r = longint'(it.search_radius);
    r2 = r * r;
    limit = match_limit_reg;
    if (limit < 1) limit = 1;
    if (limit > MAX_RESULTS) limit = MAX_RESULTS;
    if (skip_self) begin
      px = where_x[id]; py = where_y[id]; pz = where_z[id];
    end else begin
      px = it.pos_x; py = it.pos_y; pz = it.pos_z;
    end
    lx = axis_cell(px - r); hx = axis_cell(px + r);
    ly = axis_cell(py - r); hy = axis_cell(py + r);
    lz = axis_cell(pz - r); hz = axis_cell(pz + r);
    cnt = 0;
    for (int x = lx; x <= hx; x++) begin
      for (int y = ly; y <= hy; y++) begin
        for (int z = lz; z <= hz; z++) begin
          e = head_of[(x * GRID + y) * GRID + z];
          steps = 0;
          while (e < NO_SLOT && steps < SLOTS) begin
            steps++;
            if (!(skip_self && e == 9'(id))) begin
              d2 = sq(px, where_x[e]) + sq(py, where_y[e]) + sq(pz, where_z[e]);
              if (d2 < r2) begin
                cnt++;
                m.found_entity = e[7:0];
                m.found = 1'b1;
                m.match_count = 7'(cnt);
                m.last = (cnt >= limit);
                expected_results.push_back(m);
                if (cnt >= limit) begin
                  match_total += cnt;
                  return;
                end
              end
            end
            e = next_of[e];
          end
        end
      end
    end
    if (cnt == 0) begin
      push_ack();
    end else begin
      m = expected_results.pop_back();
      m.last = 1'b1;
      expected_results.push_back(m);
      match_total += cnt;
    end
  endfunction

  // Apply one accepted item to the shadow state and queue its results.
  function automatic void predict_item(in_item_t it);
    int id;
    id = it.entity_id;
    case (it.kind)
      KIND_INSERT: begin
        if (linked[id]) unlink_slot(id);
        where_x[id] = it.pos_x; where_y[id] = it.pos_y; where_z[id] = it.pos_z;
        link_slot(id);
        push_ack();
      end
      KIND_REMOVE: begin
        if (linked[id]) unlink_slot(id);
        push_ack();
      end
      KIND_MOVE: begin
        where_x[id] = it.pos_x; where_y[id] = it.pos_y; where_z[id] = it.pos_z;
        if (linked[id] && cell_at(it.pos_x, it.pos_y, it.pos_z) != home_cell[id]) begin
          unlink_slot(id);
          link_slot(id);
        end
        push_ack();
      end
      KIND_QPOINT, KIND_QENT: run_query(it);
      default: push_ack();
    endcase
  endfunction

  assign pending_count = expected_results.size();

  // Watch the channels on every rising edge.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      match_limit_reg <= MAX_MATCHES_RESET;
      for (int i = 0; i < CELLS; i++) head_of[i] = NO_SLOT;
      for (int i = 0; i < SLOTS; i++) begin
        next_of[i] = '0; prev_of[i] = '0; home_cell[i] = 0; linked[i] = 0;
        where_x[i] = 0; where_y[i] = 0; where_z[i] = 0;
      end
      expected_results.delete();
      error_count <= 0;
      item_count <= 0;
      match_total = 0;
    end else begin
      if (cfg_we) match_limit_reg <= cfg_wdata;
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, out_item);
          error_count <= error_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want != out_item) begin
            $display({"%0t: mismatch: expected ent=%0d found=%b last=%b cnt=%0d, ",
                      "actual ent=%0d found=%b last=%b cnt=%0d"},
                     $time, want.found_entity, want.found, want.last, want.match_count,
                     out_item.found_entity, out_item.found, out_item.last,
                     out_item.match_count);
            error_count <= error_count + 1;
          end
        end
      end
      if (start && !busy) begin
        predict_item(in_item);
        item_count <= item_count + 1;
      end
    end
  end

endmodule

[sim/grid_cell_neighbor_search_tb.sv]
// Top of the grid cell neighbor search testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module grid_cell_neighbor_search_tb;
  import gcns_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_strobe;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;
  int        error_count, pending_count, item_count, match_total;

  bit        pos_written[256];
  int        gap_percent;

  always #5 clk = ~clk;

  grid_cell_neighbor_search dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  grid_cell_neighbor_search_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .error_count(error_count), .pending_count(pending_count),
    .item_count(item_count), .match_total(match_total)
  );

  // Present one item and hold it until the block takes it, then maybe pause.
  task automatic send_item(logic [2:0] kind, logic [7:0] id, logic [15:0] x,
                           logic [15:0] y, logic [15:0] z, logic [15:0] radius);
    in_item_t it;
    it.kind = kind; it.entity_id = id;
    it.pos_x = x; it.pos_y = y; it.pos_z = z; it.search_radius = radius;
    if (kind == KIND_INSERT || kind == KIND_MOVE) pos_written[id] = 1'b1;
    in_item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(99) < gap_percent) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_match_limit(logic [6:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Coordinate near one of a few cluster centers, or anywhere.
  function automatic logic [15:0] pick_coord();
    int c;
    if ($urandom_range(9) < 2) return 16'($urandom);
    c = $urandom_range(3) * 12000 - 18000;
    return 16'(c + $urandom_range(3000) - 1500);
  endfunction

  function automatic logic [15:0] pick_radius();
    int p;
    p = $urandom_range(99);
    if (p < 5) return 16'd0;
    if (p < 8) return 16'hFFFF;
    if (p < 12) return 16'($urandom);
    return 16'($urandom_range(500, 9000));
  endfunction

  task automatic random_item();
    int p;
    logic [7:0] id;
    p = $urandom_range(99);
    id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(31));
    if (p < 5) begin
      send_item(3'($urandom_range(5, 7)), 8'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom));
    end else if (p < 35) begin
      send_item(KIND_INSERT, id, pick_coord(), pick_coord(), pick_coord(), 16'($urandom));
    end else if (p < 45) begin
      send_item(KIND_REMOVE, id, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
    end else if (p < 58) begin
      send_item(KIND_MOVE, id, pick_coord(), pick_coord(), pick_coord(), 16'($urandom));
    end else if (p < 80 || !pos_written[id]) begin
      send_item(KIND_QPOINT, 8'($urandom), pick_coord(), pick_coord(), pick_coord(),
                pick_radius());
    end else begin
      send_item(KIND_QENT, id, 16'($urandom), 16'($urandom), 16'($urandom), pick_radius());
    end
  endtask

  initial begin
    gap_percent = 10;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes, shared cells, relinking and unknown kinds.
    send_item(KIND_INSERT, 8'd0, 16'h8000, 16'h8000, 16'h8000, 16'd0);
    send_item(KIND_INSERT, 8'd255, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_item(KIND_INSERT, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(KIND_INSERT, 8'd2, 16'd100, 16'd0, 16'd0, 16'd0);
    send_item(KIND_INSERT, 8'd3, 16'd50, 16'd50, 16'd0, 16'd0);
    send_item(KIND_QPOINT, 8'd0, 16'd0, 16'd0, 16'd0, 16'd200);
    send_item(KIND_QENT, 8'd1, 16'd0, 16'd0, 16'd0, 16'd200);
    send_item(KIND_QPOINT, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(KIND_QPOINT, 8'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    send_item(KIND_INSERT, 8'd2, 16'd10, 16'd0, 16'd0, 16'd0);
    send_item(KIND_MOVE, 8'd3, 16'd60, 16'd50, 16'd0, 16'd0);
    send_item(KIND_MOVE, 8'd1, 16'd12000, 16'd0, 16'd0, 16'd0);
    send_item(KIND_REMOVE, 8'd2, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(KIND_REMOVE, 8'd2, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(KIND_MOVE, 8'd9, 16'd5, 16'd5, 16'd5, 16'd0);
    send_item(KIND_QENT, 8'd9, 16'd0, 16'd0, 16'd0, 16'd20000);
    send_item(3'd5, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(3'd7, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(KIND_REMOVE, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(KIND_REMOVE, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(KIND_REMOVE, 8'd3, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(KIND_REMOVE, 8'd255, 16'd0, 16'd0, 16'd0, 16'd0);

    // Random phases with different match limits and idle patterns.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_match_limit(7'd1);
        1: set_match_limit(7'd64);
        2: set_match_limit(7'd0);
        3: set_match_limit(7'd127);
        default: set_match_limit(7'($urandom_range(2, 20)));
      endcase
      gap_percent = (ph < 2) ? 10 : (ph < 4) ? 58 : 0;
      repeat (36) random_item();
    end

    drain();
    $display("tb: %0d items sent across five match limits, %0d matches predicted", item_count,
             match_total);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #200ms;
    $display("tb: failure");
    $finish;
  end

endmodule
